// ----- src/vsd_pkg.sv -----
// Shared types and constants for the varint stream decoder.
`default_nettype none

package vsd_pkg;

    localparam int DATA_W  = 8;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 4;
    localparam int STAT_W  = 2;

    // Longest number accepted, in bytes
    localparam int MAX_BYTES_DEF = 10;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NEED_MORE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ZERO_CONT = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_TOO_LONG  = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] number_value;
        logic [COUNT_W-1:0] byte_count;
        logic [STAT_W-1:0]  status;
    } vsd_result_t;

endpackage

`default_nettype wire

// ----- src/vsd_core.sv -----
// Varint decode step: accumulator, byte counter and result selection.
`default_nettype none

module vsd_core #(
    parameter int MAX_BYTES = vsd_pkg::MAX_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic [vsd_pkg::DATA_W-1:0]   data_byte,
    input  wire logic                         buffer_end,
    output logic                              res_valid,
    output vsd_pkg::vsd_result_t              res
);

    localparam logic [vsd_pkg::COUNT_W-1:0] MAX_CNT = vsd_pkg::COUNT_W'(MAX_BYTES);
    localparam logic [vsd_pkg::COUNT_W-1:0] CNT_SAT = '1;

    logic [vsd_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [vsd_pkg::COUNT_W-1:0] cnt_reg, cnt_next;

    logic [vsd_pkg::VALUE_W-1:0] acc_merged;
    logic [vsd_pkg::COUNT_W-1:0] cnt_inc;
    logic [6:0]                  shift_amt;
    logic [vsd_pkg::VALUE_W-1:0] payload;

    always_comb
    begin
        shift_amt  = {3'b000, cnt_reg} * 7'd7;
        payload    = {{(vsd_pkg::VALUE_W-7){1'b0}}, data_byte[6:0]};
        // cnt below MAX_BYTES keeps the shift under 64
        acc_merged = (cnt_reg < MAX_CNT) ? (acc_reg | (payload << shift_amt)) : acc_reg;
        cnt_inc    = (cnt_reg != CNT_SAT) ? cnt_reg + 1'b1 : cnt_reg;

        res_valid  = 1'b0;
        res        = '0;
        acc_next   = acc_merged;
        cnt_next   = cnt_inc;

        if (cnt_reg != '0 && data_byte == '0)
        begin
            res_valid  = 1'b1;
            res.status = vsd_pkg::STATUS_ZERO_CONT;
        end
        else if (!data_byte[7])
        begin
            res_valid        = 1'b1;
            res.number_value = acc_merged;
            res.byte_count   = cnt_inc;
            res.status       = vsd_pkg::STATUS_OK;
        end
        else if (cnt_inc >= MAX_CNT)
        begin
            res_valid  = 1'b1;
            res.status = vsd_pkg::STATUS_TOO_LONG;
        end
        else if (buffer_end)
        begin
            res_valid  = 1'b1;
            res.status = vsd_pkg::STATUS_NEED_MORE;
        end

        // any result restarts decoding
        if (res_valid)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (fire)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/vsd_out_buf.sv -----
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module vsd_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire vsd_pkg::vsd_result_t push_data,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output vsd_pkg::vsd_result_t      out_data,
    output logic                      full
);

    logic                 head_valid_reg, head_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    vsd_pkg::vsd_result_t head_reg, head_next;
    vsd_pkg::vsd_result_t skid_reg, skid_next;
    logic                 pop;

    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;
    assign full      = skid_valid_reg;
    assign pop       = head_valid_reg && !out_stall;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                head_valid_next = push;
                head_next       = push_data;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
            else
            begin
                head_valid_next = 1'b1;
                head_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

// ----- src/varint_stream_decoder.sv -----
// Top level of the streaming unsigned LEB128 varint decoder.
//
// Takes one byte per transaction and emits one result transaction when a
// number ends or an error is found: terminator byte (bit 7 clear) gives the
// value, byte count and status ok; a zero byte after a continuation byte,
// a continuation byte reaching MAX_BYTES, or a continuation byte flagged
// buffer_end gives value 0, count 0 and the matching error status, and
// decoding restarts at the next byte. Continuation bytes mid-buffer give
// no result. Throughput is one byte per cycle while in_stall is low; a result
// reaches the output after its byte passes through the input register and
// the decode step, a 64-bit shift-or plus compares, writes it into the
// result buffer. The result side holds two entries (output plus skid
// register), so input keeps flowing while one result waits under out_stall;
// in_stall rises only when both are full and the input register holds a
// byte.
`default_nettype none

module varint_stream_decoder #(
    parameter int MAX_BYTES = vsd_pkg::MAX_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [vsd_pkg::DATA_W-1:0]    data_byte,
    input  wire logic                          buffer_end,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [vsd_pkg::VALUE_W-1:0]        number_value,
    output logic [vsd_pkg::COUNT_W-1:0]        byte_count,
    output logic [vsd_pkg::STAT_W-1:0]         status
);

    // input register
    logic                        in_vld_reg;
    logic [vsd_pkg::DATA_W-1:0]  byte_reg;
    logic                        end_reg;

    logic                        in_accept;
    logic                        step;
    logic                        buf_full;
    logic                        res_valid;
    vsd_pkg::vsd_result_t        res;
    vsd_pkg::vsd_result_t        out_data;

    // the held byte steps whenever the result buffer has a free entry
    assign step      = in_vld_reg && !buf_full;
    assign in_stall  = in_vld_reg && buf_full;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (step)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= data_byte;
            end_reg  <= buffer_end;
        end
    end

    vsd_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (step),
        .data_byte  (byte_reg),
        .buffer_end (end_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    vsd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign number_value = out_data.number_value;
    assign byte_count   = out_data.byte_count;
    assign status       = out_data.status;

endmodule

`default_nettype wire
